>>> rtl/rogma_pkg.sv
// ----------------------------------------------------------------------------
// rogma_pkg
// shared widths, register indexes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package rogma_pkg;

   localparam int RANGE_W = 12;
   localparam int CSR_IDX_W = 4;
   localparam int DIV_CNT_W = 4;

   localparam logic [RANGE_W-1:0] HALF_INCH = 12'd8;
   localparam logic [RANGE_W-1:0] LIMIT_RESET = 12'd800;

   localparam logic [CSR_IDX_W-1:0] CSR_GATE_ENABLE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_LIMIT = 4'd1;

   typedef struct packed {
      logic load;
      logic sum_step;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic sum_last;
      logic div_last;
   } stat_type;

endpackage

>>> rtl/rogma_if.sv
// ----------------------------------------------------------------------------
// rogma channel interfaces
// sample, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface rogma_req_if;
   import rogma_pkg::*;
   logic valid;
   logic ready;
   logic [RANGE_W-1:0] range_sample;
   modport source (output valid, output range_sample, input ready);
   modport sink (input valid, input range_sample, output ready);
endinterface

interface rogma_rsp_if;
   import rogma_pkg::*;
   logic valid;
   logic ready;
   logic [RANGE_W-1:0] filtered_range;
   modport source (output valid, output filtered_range, input ready);
   modport sink (input valid, input filtered_range, output ready);
endinterface

interface rogma_csr_if;
   import rogma_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RANGE_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/rogma_datapath.sv
// ----------------------------------------------------------------------------
// rogma_datapath
// gate, sample ring, serial sum and restoring divide, result register
// ----------------------------------------------------------------------------
module rogma_datapath #(
   parameter int WINDOW = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rogma_pkg::cmd_type         cmd,
   output rogma_pkg::stat_type        stat,
   input  logic [rogma_pkg::RANGE_W-1:0] req_range_sample,
   output logic [rogma_pkg::RANGE_W-1:0] rsp_filtered_range,
   input  logic                       csr_write,
   input  logic [rogma_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rogma_pkg::RANGE_W-1:0] csr_data
);
   import rogma_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = RANGE_W + CNT_W;

   logic [RANGE_W-1:0] ring_ff [WINDOW];
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [RANGE_W-1:0] dq_ff, dq_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [RANGE_W-1:0] last_ff, last_in;
   logic [RANGE_W-1:0] out_ff, out_in;
   logic               gate_en_ff, gate_en_in;
   logic [RANGE_W-1:0] gate_lim_ff, gate_lim_in;

   logic [RANGE_W:0]   gate_hi;
   logic [RANGE_W-1:0] gated;
   logic [RANGE_W-1:0] entry;
   logic [CNT_W:0]     shifted;
   logic [CNT_W:0]     diff;
   logic               fits;
   logic [RANGE_W:0]   biased;
   logic [RANGE_W-1:0] result;

   // outlier gate against the last output
   always_comb begin
      gate_hi = {1'b0, last_ff} + {1'b0, gate_lim_ff};
      gated = req_range_sample;
      if (gate_en_ff) begin
         if ({1'b0, req_range_sample} > gate_hi) begin
            gated = last_ff;
         end else if (last_ff > gate_lim_ff && req_range_sample < last_ff - gate_lim_ff) begin
            gated = last_ff;
         end
      end
   end

   always_comb begin
      entry = ring_ff[idx_ff];
      shifted = {rem_ff, dq_ff[RANGE_W-1]};
      diff = shifted - {1'b0, cnt_ff};
      fits = shifted >= {1'b0, cnt_ff};
      biased = {1'b0, dq_ff} + {1'b0, HALF_INCH};
      if (cnt_ff == '0) begin
         result = '0;
      end else if (biased[RANGE_W]) begin
         result = '1;
      end else begin
         result = biased[RANGE_W-1:0];
      end
   end

   always_comb begin
      slot_in = slot_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dq_in = dq_ff;
      dcnt_in = dcnt_ff;
      last_in = last_ff;
      out_in = out_ff;
      gate_en_in = gate_en_ff;
      gate_lim_in = gate_lim_ff;
      if (cmd.load) begin
         slot_in = (slot_ff == IDX_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         idx_in = '0;
         sum_in = '0;
         cnt_in = '0;
      end
      if (cmd.sum_step) begin
         idx_in = idx_ff + 1'b1;
         if (entry != '0) begin
            sum_in = sum_ff + SUM_W'(entry);
            cnt_in = cnt_ff + 1'b1;
         end
      end
      // quotient fits in RANGE_W bits, so the upper sum bits start the remainder
      if (cmd.div_init) begin
         rem_in = sum_ff[SUM_W-1:RANGE_W];
         dq_in = sum_ff[RANGE_W-1:0];
         dcnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         dq_in = {dq_ff[RANGE_W-2:0], fits};
         dcnt_in = dcnt_ff + 1'b1;
      end
      if (cmd.finish) begin
         last_in = result;
         out_in = result;
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_GATE_ENABLE: gate_en_in = csr_data[0];
            CSR_GATE_LIMIT:  gate_lim_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            ring_ff[k] <= '0;
         end
         slot_ff <= '0;
         last_ff <= '0;
         gate_en_ff <= 1'b0;
         gate_lim_ff <= LIMIT_RESET;
      end else begin
         if (cmd.load) begin
            ring_ff[slot_ff] <= gated;
         end
         slot_ff <= slot_in;
         last_ff <= last_in;
         gate_en_ff <= gate_en_in;
         gate_lim_ff <= gate_lim_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dq_ff <= dq_in;
      dcnt_ff <= dcnt_in;
      out_ff <= out_in;
   end

   assign stat.sum_last = (idx_ff == IDX_W'(WINDOW - 1));
   assign stat.div_last = (dcnt_ff == DIV_CNT_W'(RANGE_W - 1));
   assign rsp_filtered_range = out_ff;

endmodule

>>> rtl/rogma_ctrl.sv
// ----------------------------------------------------------------------------
// rogma_ctrl
// sequencer for load, sum, divide and result hand-off
// ----------------------------------------------------------------------------
module rogma_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rogma_pkg::stat_type stat,
   output rogma_pkg::cmd_type  cmd
);
   import rogma_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SUM   = 5'b00010,
      ST_DINIT = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.sum_last) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // result register never overwritten while a transaction is pending
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

   a_accept_sum: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SUM))
      else $error("accepted sample not summed");

   a_sum_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && stat.sum_last) |=> (state_ff == ST_DINIT))
      else $error("sum sweep did not end at divide");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished result not presented");

endmodule

>>> rtl/range_outlier_gate_moving_average.sv
// ----------------------------------------------------------------------------
// range_outlier_gate_moving_average
// gated moving average of range samples over a ring of WINDOW entries
// the result is built by a serial ring sum (one entry a cycle) and a 12-step
// restoring divide; a new sample is taken only once the last result is registered
// reset clears the ring, write slot, last output and gate registers at once
// ----------------------------------------------------------------------------
module range_outlier_gate_moving_average #(
   parameter int WINDOW = 10
) (
   input  logic       clock,
   input  logic       reset,
   rogma_req_if.sink   req_bus,
   rogma_rsp_if.source rsp_bus,
   rogma_csr_if.sink   csr_bus
);
   import rogma_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_bus.ready = 1'b1;

   rogma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rogma_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_range_sample   (req_bus.range_sample),
      .rsp_filtered_range (rsp_bus.filtered_range),
      .csr_write          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data)
   );

endmodule
